// ===== rtl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, request opcodes and result status codes of the positional
// list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  // default number of list cells
  localparam int DEF_CAPACITY = 16;

  // field widths of one transaction
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 5;

  typedef logic [OPCODE_W-1:0]      opcode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [ECOUNT_W-1:0]      ecount_t;

  // request opcodes
  localparam opcode_t OP_ADD_HEAD  = 3'd0;
  localparam opcode_t OP_ADD_TAIL  = 3'd1;
  localparam opcode_t OP_INSERT    = 3'd2;
  localparam opcode_t OP_TAKE_HEAD = 3'd3;
  localparam opcode_t OP_ERASE     = 3'd4;
  localparam opcode_t OP_DUMP      = 3'd5;
  localparam opcode_t OP_CLEAR     = 3'd6;

  // result status codes
  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_ADJUSTED = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_DUMPED   = 3'd4;

endpackage

// ===== rtl/pls_if.sv =====
// ----------------------------------------------------------------------------
// pls_if
// Valid/ready channels of the positional list store: the request channel
// and the result channel.
// ----------------------------------------------------------------------------
interface pls_in_if;
  import pls_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  value_t  item_value;
  pos_t    position;

  modport source (output valid, output opcode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input position,
                  output ready);
endinterface

interface pls_out_if;
  import pls_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  element_value;
  ecount_t element_count;
  logic    last_of_run;

  modport source (output valid, output status, output element_value,
                  output element_count, output last_of_run, input ready);
  modport sink   (input valid, input status, input element_value,
                  input element_count, input last_of_run, output ready);
endinterface

// ===== rtl/positional_list_store_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_core
// Bounded ordered list of signed 32-bit values kept packed in one memory;
// insert and erase move the tail one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request (opcode, item_value, position) per transaction.
//   out_ch carries the results; every request yields one result with
//   last_of_run set, except a dump of a non-empty list, which yields one
//   result per held element, front to back, the last one marked.
//   in_ch.ready is high only while no request is in progress; the finished
//   result sits in an output register, so a new request is taken while it
//   still waits for out_ch.ready.
// Request sequence (n = cells moved, at most count): push/insert and
//   pop/erase move n cells, each move being one memory read overlapped
//   with the write of the previous one, then the last write; push/insert
//   then writes the new value; clear, rejected or empty requests do no
//   memory work; dump streams one element per cycle while out_ch is ready.
//   The single memory write port sets this pace.
// Reset: rst_n (synchronous, active low) empties the list and drops any
//   pending result; no clearing pass of the memory is needed.
// Stalls: while out_ch.ready is low the block holds its result and waits.
// ----------------------------------------------------------------------------
module positional_list_store_core #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_ch,
  pls_out_if.source out_ch
);
  import pls_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOVE = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          op_ins_r, op_ins_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  value_t        value_r, value_nxt;
  status_t       status_r, status_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [CW-1:0] mv_left_r, mv_left_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_dst_r, pend_dst_nxt;
  logic [CW-1:0] dump_idx_r, dump_idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  value_t        out_value_r, out_value_nxt;
  ecount_t       out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  value_t        mem_rdata;

  logic          accept;
  logic          out_free;
  logic          full, empty;
  logic [PW-1:0] pos_u, cnt_u;
  logic          pos_neg, pos_ge;
  logic [CW-1:0] tgt_idx;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] dump_next;
  logic [CW+4:0] count_ext;

  pls_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake and request decode helpers
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (count_r == CAP_C);
  assign empty       = (count_r == '0);
  assign count_dec   = count_r - 1'b1;
  assign pos_u       = PW'(in_ch.position[POS_W-2:0]);
  assign cnt_u       = PW'(count_r);
  assign pos_neg     = in_ch.position[POS_W-1];
  assign pos_ge      = !pos_neg && (pos_u >= cnt_u);
  assign dump_next   = dump_idx_r + 1'b1;
  assign count_ext   = {5'd0, count_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_ins_nxt     = op_ins_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    src_nxt        = src_r;
    mv_left_nxt    = mv_left_r;
    pend_nxt       = 1'b0;
    pend_dst_nxt   = pend_dst_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = pend_dst_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = src_r;
    tgt_idx        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt  = in_ch.item_value;
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
          case (in_ch.opcode) inside
            OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                if (in_ch.opcode == OP_ADD_HEAD) begin
                  tgt_idx = '0;
                end else if (in_ch.opcode == OP_ADD_TAIL) begin
                  tgt_idx = count_r;
                end else if (pos_neg) begin
                  tgt_idx    = '0;
                  status_nxt = ST_ADJUSTED;
                end else if (pos_ge) begin
                  tgt_idx    = count_r;
                  status_nxt = ST_ADJUSTED;
                end else begin
                  tgt_idx = pos_u[CW-1:0];
                end
                op_ins_nxt  = 1'b1;
                idx_nxt     = tgt_idx[AW-1:0];
                mv_left_nxt = count_r - tgt_idx;
                src_nxt     = count_dec[AW-1:0];
                count_nxt   = count_r + 1'b1;
                state_nxt   = S_MOVE;
              end
            end
            OP_TAKE_HEAD, OP_ERASE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                if (in_ch.opcode == OP_TAKE_HEAD) begin
                  tgt_idx = '0;
                end else if (pos_neg) begin
                  tgt_idx    = '0;
                  status_nxt = ST_ADJUSTED;
                end else if (pos_ge) begin
                  tgt_idx    = count_dec;
                  status_nxt = ST_ADJUSTED;
                end else begin
                  tgt_idx = pos_u[CW-1:0];
                end
                op_ins_nxt  = 1'b0;
                mv_left_nxt = count_dec - tgt_idx;
                src_nxt     = tgt_idx[AW-1:0] + 1'b1;
                count_nxt   = count_dec;
                state_nxt   = S_MOVE;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = '0;
                dump_idx_nxt = '0;
                state_nxt    = S_DUMP;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end

      // read one cell per cycle, write it one slot over in the next cycle
      S_MOVE: begin
        mem_we = pend_r;
        if (mv_left_r != '0) begin
          mem_re       = 1'b1;
          mem_raddr    = src_r;
          pend_nxt     = 1'b1;
          pend_dst_nxt = op_ins_r ? (src_r + 1'b1) : (src_r - 1'b1);
          src_nxt      = op_ins_r ? (src_r - 1'b1) : (src_r + 1'b1);
          mv_left_nxt  = mv_left_r - 1'b1;
        end else begin
          // last move write, if any, lands in this cycle
          state_nxt = op_ins_r ? S_FILL : S_RESP;
        end
      end

      // drop the new value into the opened cell
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = value_r;
        state_nxt = S_RESP;
      end

      // single result of a non-dump request
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = '0;
          out_count_nxt  = count_ext[ECOUNT_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // stream held elements, next read issued as each one is taken
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUMPED;
          out_value_nxt  = mem_rdata;
          out_count_nxt  = count_ext[ECOUNT_W-1:0];
          out_last_nxt   = (dump_next == count_r);
          if (dump_next == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re       = 1'b1;
            mem_raddr    = dump_next[AW-1:0];
            dump_idx_nxt = dump_next;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_ins_r     <= op_ins_nxt;
    idx_r        <= idx_nxt;
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    src_r        <= src_nxt;
    mv_left_r    <= mv_left_nxt;
    pend_dst_r   <= pend_dst_nxt;
    dump_idx_r   <= dump_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_value = out_value_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.last_of_run   = out_last_r;

  // the list never holds more than its capacity
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP_C)
    else $error("element count above capacity");

  // a pending move write never lands on the cell read in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) && pend_r && mem_re |-> pend_dst_r != mem_raddr)
    else $error("move write collides with move read");

  // any request other than clear changes the count by at most one
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.opcode != OP_CLEAR) |=>
      (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
      (count_r == $past(count_r) - 1'b1))
    else $error("count changed by more than one");

  // dump only walks cells that are held
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> dump_idx_r < count_r)
    else $error("dump index beyond held elements");

  // new requests are taken only while no move is outstanding
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !pend_r)
    else $error("request taken during a move");

endmodule

// ===== rtl/pls_mem.sv =====
// ----------------------------------------------------------------------------
// pls_mem
// Element storage: one write port, one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module pls_mem #(
  parameter int DEPTH = pls_pkg::DEF_CAPACITY,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  pls_pkg::value_t      wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output pls_pkg::value_t      rdata
);
  import pls_pkg::*;

  value_t mem [DEPTH];
  value_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== test/positional_list_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_core_tb
// Drives list requests (pushes, positional inserts, pops, erases, dumps and
// clears) through the request channel and checks every result against a
// queue-based prediction of the list, under several idle and stall mixes
// plus one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module positional_list_store_core_tb;
  import pls_pkg::*;

  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int ITEM_COUNT = 420;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 500000;

  typedef struct packed {
    status_t status;
    value_t  element_value;
    ecount_t element_count;
    logic    last_of_run;
  } list_result_t;

  // list contents and pending results as the block should see them
  class list_scoreboard;
    value_t       cells[$];
    list_result_t pending[$];
    int           errors;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void expect_result(status_t st, value_t v, logic last);
      list_result_t r;
      r.status        = st;
      r.element_value = v;
      r.element_count = ecount_t'(cells.size());
      r.last_of_run   = last;
      pending.insert(pending.size(), r);
    endfunction

    // apply one accepted request to the list and queue its results
    function void note_request(opcode_t op, value_t v, pos_t p);
      int      n;
      status_t st;
      n  = cells.size();
      st = ST_DONE;
      case (op)
        OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT: begin
          if (n >= CAPACITY) st = ST_FULL;
          else if (op == OP_ADD_HEAD) cells.insert(0, v);
          else if (op == OP_ADD_TAIL) cells.insert(n, v);
          else if (p < 0) begin
            cells.insert(0, v);
            st = ST_ADJUSTED;
          end else if (int'(p) >= n) begin
            cells.insert(n, v);
            st = ST_ADJUSTED;
          end else cells.insert(int'(p), v);
        end
        OP_TAKE_HEAD: begin
          if (n == 0) st = ST_EMPTY;
          else cells.delete(0);
        end
        OP_ERASE: begin
          if (n == 0) st = ST_EMPTY;
          else if (p < 0) begin
            cells.delete(0);
            st = ST_ADJUSTED;
          end else if (int'(p) >= n) begin
            cells.delete(n - 1);
            st = ST_ADJUSTED;
          end else cells.delete(int'(p));
        end
        OP_DUMP: begin
          if (n == 0) st = ST_EMPTY;
          else begin
            for (int i = 0; i < n; i++)
              expect_result(ST_DUMPED, cells[i], i == n - 1);
            return;
          end
        end
        OP_CLEAR: cells.delete();
        default: ;
      endcase
      expect_result(st, '0, 1'b1);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: st=%0d val=%0d cnt=%0d last=%0b",
                       got.status, got.element_value, got.element_count,
                       got.last_of_run));
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.status !== want.status || got.element_value !== want.element_value ||
          got.element_count !== want.element_count ||
          got.last_of_run !== want.last_of_run)
        flag($sformatf("result mismatch: exp st=%0d val=%0d cnt=%0d last=%0b, %s",
                       want.status, want.element_value, want.element_count,
                       want.last_of_run,
                       $sformatf("got st=%0d val=%0d cnt=%0d last=%0b",
                                 got.status, got.element_value,
                                 got.element_count, got.last_of_run)));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pls_in_if  in_ch ();
  pls_out_if out_ch ();

  positional_list_store_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             requests_sent;
  int             cycles;
  logic           hold_req;
  logic           hold_off;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("positional_list_store_core_tb: done, errors");
      $finish;
    end
  end

  // observe both channels at the rising edge
  always @(posedge clk) begin : observe
    list_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.opcode, in_ch.item_value, in_ch.position);
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.element_value = out_ch.element_value;
        got.element_count = out_ch.element_count;
        got.last_of_run   = out_ch.last_of_run;
        sb.check_result(got);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long hold-off, counted on the rising edge
  initial begin
    hold_off = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  // one request transaction, entered and left at a falling edge
  task automatic issue_request(input opcode_t op, input value_t v, input pos_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= v;
    in_ch.position   <= p;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic set_idle_mix(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return value_t'($urandom());
    endcase
  endfunction

  // mostly around the list bounds, sometimes anywhere in the field
  function automatic pos_t pick_position(input int n);
    if ($urandom_range(0, 3) == 0) return pos_t'($urandom_range(0, 255));
    return pos_t'($urandom_range(0, n + 3) - 1);
  endfunction

  function automatic opcode_t pick_insert_op();
    case ($urandom_range(0, 2))
      0: return OP_ADD_HEAD;
      1: return OP_ADD_TAIL;
      default: return OP_INSERT;
    endcase
  endfunction

  function automatic opcode_t pick_remove_op();
    return $urandom_range(0, 1) ? OP_TAKE_HEAD : OP_ERASE;
  endfunction

  // grow to full, push past it, then dump
  task automatic fill_list();
    while (sb.cells.size() < CAPACITY)
      issue_request(pick_insert_op(), pick_value(), pick_position(sb.cells.size()));
    repeat ($urandom_range(1, 3))
      issue_request(pick_insert_op(), pick_value(), pick_position(CAPACITY));
    issue_request(OP_DUMP, pick_value(), pick_position(CAPACITY));
  endtask

  // shrink to empty, remove past it, then dump
  task automatic drain_list();
    while (sb.cells.size() > 0)
      issue_request(pick_remove_op(), pick_value(), pick_position(sb.cells.size()));
    repeat ($urandom_range(1, 2))
      issue_request(pick_remove_op(), pick_value(), pick_position(0));
    issue_request(OP_DUMP, pick_value(), pick_position(0));
  endtask

  task automatic mixed_burst();
    int      r;
    opcode_t op;
    repeat (12) begin
      r = $urandom_range(0, 99);
      if (r < 50) op = pick_insert_op();
      else if (r < 80) op = pick_remove_op();
      else if (r < 93) op = OP_DUMP;
      else op = OP_CLEAR;
      issue_request(op, pick_value(), pick_position(sb.cells.size()));
    end
  endtask

  initial begin
    int kind;
    sb             = new();
    rst_n          = 1'b0;
    hold_req       = 1'b0;
    cycles         = 0;
    requests_sent  = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_ADD_HEAD;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    set_idle_mix(0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, field extremes, position clamping
    issue_request(OP_DUMP,       '0,           '0);
    issue_request(OP_TAKE_HEAD,  '0,           '0);
    issue_request(OP_ERASE,      '0,           '0);
    issue_request(OP_INSERT,     32'sh1,       8'sh80);
    issue_request(OP_ADD_HEAD,   32'sh7FFFFFFF, '0);
    issue_request(OP_ADD_TAIL,   32'sh80000000, '0);
    issue_request(OP_INSERT,     '1,           8'sh7F);
    issue_request(OP_INSERT,     32'sh55555555, 8'sd1);
    issue_request(OP_INSERT,     32'shAAAAAAAA, 8'sd5);
    issue_request(OP_INSERT,     32'sh2,       '1);
    issue_request(OP_DUMP,       '0,           '0);
    issue_request(OP_ERASE,      '0,           8'sh7F);
    issue_request(OP_ERASE,      '0,           8'sh80);
    issue_request(OP_ERASE,      '0,           8'sd1);
    issue_request(OP_TAKE_HEAD,  '0,           '0);
    issue_request(OP_DUMP,       '0,           '0);
    issue_request(OP_CLEAR,      '0,           '0);
    issue_request(OP_DUMP,       '0,           '0);

    // random runs, idle mix rotating every hundred requests
    fill_list();
    while (requests_sent < ITEM_COUNT) begin
      set_idle_mix((requests_sent / 100) % 4);
      if (!hold_req && requests_sent >= 60) hold_req = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 30) fill_list();
      else if (kind < 55) drain_list();
      else mixed_burst();
    end
    in_ch.valid <= 1'b0;

    // let outstanding results arrive, then a short quiet tail
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending.size()));

    if (sb.errors == 0) $display("positional_list_store_core_tb: done, clean");
    else $display("positional_list_store_core_tb: done, errors");
    $finish;
  end

endmodule
